// ===== src/msep_pkg.sv =====
package msep_pkg;

    // Defaults for the top level parameters.
    localparam int SEP_COUNT_DEFAULT = 4;
    localparam int SEP_BYTES_DEFAULT = 4;

    // Fixed register layout of the configuration port.
    localparam int PATTERN_REGS  = 4;
    localparam int PATTERN_BYTES = 4;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 3;
    localparam int LENGTHS_W     = LEN_W * PATTERN_REGS;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int PAT_IDX_W     = $clog2(PATTERN_REGS);

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_ZERO    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_THREE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTHS = 3'd4;

    localparam logic [CFG_DATA_W-1:0] PATTERN_ZERO_RESET  = 32'd32;
    localparam logic [CFG_DATA_W-1:0] PATTERN_OTHER_RESET = 32'd0;
    localparam logic [LENGTHS_W-1:0]  LENGTHS_RESET       = 12'd1;

    // Output queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              final_byte;
    } text_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] word_byte;
        logic              byte_present;
        logic              word_end;
        logic              string_end;
    } word_item_t;

    // Contents of one lookahead cell.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
        logic              valid;
    } cell_data_t;

    // Up to two results from one head decision; second_valid implies first_valid.
    typedef struct packed {
        logic       first_valid;
        logic       second_valid;
        word_item_t first;
        word_item_t second;
    } result_pair_t;

    // Number of separators that are really compared.
    function automatic int used_separators(input int count);
        return (count < PATTERN_REGS) ? count : PATTERN_REGS;
    endfunction

    // Longest separator that can match with a window of the given depth.
    function automatic int match_bytes(input int depth);
        return (depth < PATTERN_BYTES) ? depth : PATTERN_BYTES;
    endfunction

endpackage

// ===== src/msep_cell.sv =====
module msep_cell
    import msep_pkg::*;
#(
    parameter int SEPARATOR_COUNT = SEP_COUNT_DEFAULT
)(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cell_data_t                             feed,
    input  logic                                   take_in,
    output logic                                   take_out,
    input  logic [used_separators(SEPARATOR_COUNT)-1:0][BYTE_W-1:0] pattern_bytes,
    output cell_data_t                             content,
    output logic [used_separators(SEPARATOR_COUNT)-1:0] eq
);

    localparam int SepUsed = used_separators(SEPARATOR_COUNT);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              last_reg;
    logic              last_next;

    // The cell is free when it is empty or its byte moves on toward the head.
    assign take_out = ~valid_reg | take_in;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (take_out)
        begin
            valid_next = feed.valid;
            byte_next  = feed.data_byte;
            last_next  = feed.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign content = '{data_byte: byte_reg, last: last_reg, valid: valid_reg};

    always_comb
    begin
        for (int s = 0; s < SepUsed; s++)
        begin
            eq[s] = (byte_reg == pattern_bytes[s]);
        end
    end

endmodule

// ===== src/msep_decide.sv =====
module msep_decide
    import msep_pkg::*;
#(
    parameter int SEPARATOR_COUNT = SEP_COUNT_DEFAULT,
    parameter int SEPARATOR_BYTES = SEP_BYTES_DEFAULT
)(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  cell_data_t                                  cells [SEPARATOR_BYTES],
    input  logic [used_separators(SEPARATOR_COUNT)-1:0] eq [SEPARATOR_BYTES],
    input  logic [LENGTHS_W-1:0]                        lengths,
    input  logic                                        room,
    output logic                                        fire,
    output result_pair_t                                results
);

    localparam int SepUsed    = used_separators(SEPARATOR_COUNT);
    localparam int MatchBytes = match_bytes(SEPARATOR_BYTES);
    localparam int SkipW      = (MatchBytes > 1) ? $clog2(MatchBytes) : 1;
    localparam logic [LEN_W-1:0] LenCap = LEN_W'(MatchBytes);

    logic [SkipW-1:0]  skip_reg;
    logic [SkipW-1:0]  skip_next;
    logic              held_valid_reg;
    logic              held_valid_next;
    logic [BYTE_W-1:0] held_byte_reg;
    logic [BYTE_W-1:0] held_byte_next;

    logic [LEN_W-1:0]  sep_len [SepUsed];
    logic              found;
    logic [LEN_W-1:0]  match_len;
    logic              window_full;
    logic              to_end;

    // Separator lengths, saturated to what the window can hold.
    always_comb
    begin
        logic [LEN_W-1:0] raw;
        for (int s = 0; s < SepUsed; s++)
        begin
            raw        = lengths[LEN_W*s +: LEN_W];
            sep_len[s] = (raw > LenCap) ? LenCap : raw;
        end
    end

    // First separator, in register order, that fits within the string and matches.
    always_comb
    begin
        logic hit;
        found     = 1'b0;
        match_len = '0;
        for (int s = 0; s < SepUsed; s++)
        begin
            hit = (sep_len[s] != '0);
            for (int k = 0; k < SEPARATOR_BYTES; k++)
            begin
                if (k < int'(sep_len[s]))
                begin
                    hit = hit & cells[k].valid & eq[k][s];
                end
                if (k + 1 < int'(sep_len[s]))
                begin
                    hit = hit & ~cells[k].last;
                end
            end
            if (hit && !found)
            begin
                found     = 1'b1;
                match_len = sep_len[s];
            end
        end
    end

    // The head may be decided once the window is full or reaches its string's end.
    always_comb
    begin
        logic run;
        run    = 1'b1;
        to_end = 1'b0;
        for (int k = 0; k < SEPARATOR_BYTES; k++)
        begin
            run = run & cells[k].valid;
            if (run && cells[k].last)
            begin
                to_end = 1'b1;
            end
        end
        window_full = run;
    end

    assign fire = cells[0].valid & room & ((skip_reg != '0) | window_full | to_end);

    always_comb
    begin
        logic       held_out;
        logic       close_out;
        word_item_t held_item;
        word_item_t close_item;

        skip_next       = skip_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        held_out        = 1'b0;
        close_out       = 1'b0;
        held_item       = '{word_byte: held_byte_reg, byte_present: 1'b1,
                            word_end: 1'b0, string_end: 1'b0};
        close_item      = '{word_byte: '0, byte_present: 1'b0,
                            word_end: 1'b0, string_end: 1'b1};

        if (fire)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - SkipW'(1);
            end
            else if (found)
            begin
                held_out           = held_valid_reg;
                held_item.word_end = 1'b1;
                held_valid_next    = 1'b0;
                skip_next          = SkipW'(match_len - LEN_W'(1));
            end
            else
            begin
                held_out        = held_valid_reg;
                held_byte_next  = cells[0].data_byte;
                held_valid_next = 1'b1;
            end

            if (cells[0].last)
            begin
                close_out = 1'b1;
                if (held_valid_next)
                begin
                    close_item = '{word_byte: held_byte_next, byte_present: 1'b1,
                                   word_end: 1'b1, string_end: 1'b1};
                end
                held_valid_next = 1'b0;
            end
        end

        results.first_valid  = held_out | close_out;
        results.second_valid = held_out & close_out;
        results.first        = held_out ? held_item : close_item;
        results.second       = close_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg       <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            skip_reg       <= skip_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
    end

endmodule

// ===== src/msep_outq.sv =====
module msep_outq
    import msep_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_pair_t results,
    output logic         room,
    output logic         word_valid,
    input  logic         word_stall,
    output word_item_t   word_item
);

    word_item_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_CNT_W-1:0] push_cnt;
    logic                  pop;

    assign word_valid = (count_reg != '0);
    assign word_item  = mem_reg[rd_ptr_reg];
    assign pop        = word_valid & ~word_stall;

    // Room for the two results a single decision can make.
    assign room = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    assign push_cnt = FIFO_CNT_W'(results.first_valid) + FIFO_CNT_W'(results.second_valid);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + push_cnt - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (results.first_valid)
        begin
            mem_reg[wr_ptr_reg] <= results.first;
        end
        if (results.second_valid)
        begin
            mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= results.second;
        end
    end

endmodule

// ===== src/multi_separator_tokenizer.sv =====
// Splits a byte stream into words at up to four configurable separators of one to
// four bytes each. Bytes enter one per cycle on the text channel; the last byte of
// a string carries final_byte. Words leave one byte per result on the word channel,
// with word_end on the last byte of every word and string_end on the last result of
// the string; a string made only of separators gives a single marker-only result.
// Separators are tried in register order at every position and the first one that
// matches and fits before the string end is dropped, so leading, repeated and
// trailing separators never produce empty words. The sustained rate is one byte per
// cycle while the output queue has room. A byte walks a chain of SEPARATOR_BYTES
// lookahead cells, one cell per cycle while the cell ahead is free, and the head
// cell is decided once the chain holds a full window of its string or reaches its
// last byte, so its final results leave while the next string flows in behind it.
// Results pass a four-entry output queue; decisions pause whenever it holds more
// than two results, so a stalled output side also stops the input.
// Configuration registers should only be written while no string is in flight.
module multi_separator_tokenizer
    import msep_pkg::*;
#(
    parameter int SEPARATOR_COUNT = SEP_COUNT_DEFAULT,
    parameter int SEPARATOR_BYTES = SEP_BYTES_DEFAULT
)(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   text_valid,
    output logic                   text_stall,
    input  text_item_t             text_item,

    output logic                   word_valid,
    input  logic                   word_stall,
    output word_item_t             word_item,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SepUsed = used_separators(SEPARATOR_COUNT);

    // ------------------------------------------------------------------
    // Configuration registers. The port never pushes back.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] pattern_reg  [PATTERN_REGS];
    logic [CFG_DATA_W-1:0] pattern_next [PATTERN_REGS];
    logic [LENGTHS_W-1:0]  lengths_reg;
    logic [LENGTHS_W-1:0]  lengths_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        pattern_next = pattern_reg;
        lengths_next = lengths_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index) inside
                [REG_PATTERN_ZERO:REG_PATTERN_THREE]:
                begin
                    pattern_next[cfg_index[PAT_IDX_W-1:0]] = cfg_data;
                end
                REG_PATTERN_LENGTHS:
                begin
                    lengths_next = cfg_data[LENGTHS_W-1:0];
                end
                default:
                begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg[0] <= PATTERN_ZERO_RESET;
            for (int i = 1; i < PATTERN_REGS; i++)
            begin
                pattern_reg[i] <= PATTERN_OTHER_RESET;
            end
            lengths_reg <= LENGTHS_RESET;
        end
        else
        begin
            pattern_reg <= pattern_next;
            lengths_reg <= lengths_next;
        end
    end

    // ------------------------------------------------------------------
    // Lookahead chain. Cell 0 is the head of the window. Bytes enter at the
    // tail and move one cell toward the head whenever the cell ahead is free,
    // so gaps close up by themselves. The take signal runs from the head to
    // the tail: the head cell is freed by a decision, and each cell behind it
    // is free when it is empty or its byte moves forward in the same cycle.
    // ------------------------------------------------------------------
    cell_data_t                       cell_feed    [SEPARATOR_BYTES];
    cell_data_t                       cell_content [SEPARATOR_BYTES];
    logic [SepUsed-1:0][BYTE_W-1:0]   cell_pat     [SEPARATOR_BYTES];
    logic [SepUsed-1:0]               cell_eq      [SEPARATOR_BYTES];
    logic [SEPARATOR_BYTES-1:0]       cell_take_in;
    logic [SEPARATOR_BYTES-1:0]       cell_take;
    logic                             fire;
    logic                             room;
    result_pair_t                     results;

    for (genvar k = 0; k < SEPARATOR_BYTES; k++)
    begin : g_cell
        if (k == SEPARATOR_BYTES - 1)
        begin : g_tail
            assign cell_feed[k] = '{data_byte: text_item.text_byte,
                                    last: text_item.final_byte,
                                    valid: text_valid};
        end
        else
        begin : g_inner
            assign cell_feed[k] = cell_content[k+1];
        end

        if (k == 0)
        begin : g_head
            assign cell_take_in[k] = fire;
        end
        else
        begin : g_body
            assign cell_take_in[k] = cell_take[k-1];
        end

        // Each cell compares its byte with the matching byte of every separator.
        // Cells past the longest separator only extend the lookahead.
        for (genvar s = 0; s < SepUsed; s++)
        begin : g_pat
            if (k < PATTERN_BYTES)
            begin : g_live
                assign cell_pat[k][s] = pattern_reg[s][BYTE_W*k +: BYTE_W];
            end
            else
            begin : g_spare
                assign cell_pat[k][s] = '0;
            end
        end

        msep_cell #(
            .SEPARATOR_COUNT (SEPARATOR_COUNT)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .feed          (cell_feed[k]),
            .take_in       (cell_take_in[k]),
            .take_out      (cell_take[k]),
            .pattern_bytes (cell_pat[k]),
            .content       (cell_content[k]),
            .eq            (cell_eq[k])
        );
    end

    // An item is taken exactly when the tail cell loads it.
    assign text_stall = ~cell_take[SEPARATOR_BYTES-1];

    // ------------------------------------------------------------------
    // Head decision: separator match, skip count over a matched separator,
    // and the held word byte that waits to learn whether it ends its word.
    // ------------------------------------------------------------------
    msep_decide #(
        .SEPARATOR_COUNT (SEPARATOR_COUNT),
        .SEPARATOR_BYTES (SEPARATOR_BYTES)
    ) u_decide (
        .clk     (clk),
        .rst_n   (rst_n),
        .cells   (cell_content),
        .eq      (cell_eq),
        .lengths (lengths_reg),
        .room    (room),
        .fire    (fire),
        .results (results)
    );

    // ------------------------------------------------------------------
    // Output queue between the decision logic and the word channel.
    // ------------------------------------------------------------------
    msep_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .results    (results),
        .room       (room),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_item  (word_item)
    );

endmodule

// ===== src/msep_check.sv =====
module msep_check
    import msep_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       word_valid,
    input logic       word_stall,
    input word_item_t word_item
);

    // A result held back by the receiver stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_stall |=> word_valid && $stable(word_item))
        else $error("word item changed while stalled");

    // A result without a byte only ever closes a string.
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_item.byte_present |->
            word_item.string_end && !word_item.word_end && word_item.word_byte == '0)
        else $error("marker-only item is not a plain string close");

    // The last byte of a string always ends its word.
    a_close_word: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_item.string_end && word_item.byte_present |-> word_item.word_end)
        else $error("string closed inside an open word");

    // A byte that does not end its word is followed by another word byte.
    a_word_runs: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_stall && word_item.byte_present && !word_item.word_end |=>
            !word_valid || word_item.byte_present)
        else $error("open word followed by a marker");

endmodule

bind multi_separator_tokenizer msep_check u_msep_check (.*);

// ===== tb/sv/word_check_pkg.sv =====
`timescale 1ns / 1ps

package word_check_pkg;

    import msep_pkg::*;

    // The block is built with its default sizes, and the predictor mirrors them.
    localparam int TB_SEP_COUNT = SEP_COUNT_DEFAULT;
    localparam int TB_SEP_BYTES = SEP_BYTES_DEFAULT;

    // Tracks the separator settings and the tokenizer state. It predicts the word
    // items that each accepted text item causes and checks the word items in order.
    class word_tracker;
        logic [CFG_DATA_W-1:0] pattern [PATTERN_REGS];
        logic [LENGTHS_W-1:0]  lengths;
        logic [BYTE_W-1:0]     window [TB_SEP_BYTES];
        int unsigned           fill;
        logic [BYTE_W-1:0]     held_byte;
        bit                    held_valid;
        word_item_t            pending_words [$];
        int                    failures;
        int                    words_checked;

        function new();
            pattern[0]    = PATTERN_ZERO_RESET;
            for (int i = 1; i < PATTERN_REGS; i++)
            begin
                pattern[i] = PATTERN_OTHER_RESET;
            end
            lengths       = LENGTHS_RESET;
            fill          = 0;
            held_byte     = '0;
            held_valid    = 1'b0;
            failures      = 0;
            words_checked = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx < PATTERN_REGS)
            begin
                pattern[idx] = value;
            end
            else if (idx == REG_PATTERN_LENGTHS)
            begin
                lengths = value[LENGTHS_W-1:0];
            end
        endfunction

        // Effective separator length: zero means unused, larger values saturate.
        function int unsigned sep_len(int s);
            int unsigned n;
            n = lengths[s*LEN_W +: LEN_W];
            if (n > PATTERN_BYTES)
            begin
                n = PATTERN_BYTES;
            end
            if (n > TB_SEP_BYTES)
            begin
                n = TB_SEP_BYTES;
            end
            return n;
        endfunction

        // Length of the first separator that matches at the window head, or zero.
        function int unsigned head_match();
            int unsigned n;
            bit          hit;
            for (int s = 0; s < TB_SEP_COUNT && s < PATTERN_REGS; s++)
            begin
                n = sep_len(s);
                if (n == 0 || n > fill)
                begin
                    continue;
                end
                hit = 1'b1;
                for (int k = 0; k < n; k++)
                begin
                    if (window[k] != pattern[s][BYTE_W*k +: BYTE_W])
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    return n;
                end
            end
            return 0;
        endfunction

        function void push_word(logic [BYTE_W-1:0] value, bit present, bit wend, bit send);
            word_item_t w;
            w.word_byte    = present ? value : '0;
            w.byte_present = present;
            w.word_end     = wend;
            w.string_end   = send;
            pending_words.push_back(w);
        endfunction

        function void drop_head(int unsigned count);
            if (count > fill)
            begin
                count = fill;
            end
            for (int i = 0; i + count < fill; i++)
            begin
                window[i] = window[i + count];
            end
            fill -= count;
        endfunction

        // Called for every accepted text item.
        function void split_text(text_item_t item);
            int unsigned n;
            if (fill >= TB_SEP_BYTES)
            begin
                fill = 0;
            end
            window[fill] = item.text_byte;
            fill++;
            while (fill > 0 && (item.final_byte || fill >= TB_SEP_BYTES))
            begin
                n = head_match();
                if (n != 0)
                begin
                    if (held_valid)
                    begin
                        push_word(held_byte, 1'b1, 1'b1, 1'b0);
                    end
                    held_valid = 1'b0;
                    drop_head(n);
                end
                else
                begin
                    if (held_valid)
                    begin
                        push_word(held_byte, 1'b1, 1'b0, 1'b0);
                    end
                    held_byte  = window[0];
                    held_valid = 1'b1;
                    drop_head(1);
                end
            end
            if (item.final_byte)
            begin
                if (held_valid)
                begin
                    push_word(held_byte, 1'b1, 1'b1, 1'b1);
                end
                else
                begin
                    push_word('0, 1'b0, 1'b0, 1'b1);
                end
                held_valid = 1'b0;
                fill       = 0;
            end
        endfunction

        function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        // Called for every accepted word item.
        function void check_word(word_item_t got);
            word_item_t want;
            if (pending_words.size() == 0)
            begin
                failures++;
                $display("%0t: word item %h arrived with none expected", $time, got);
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            compare_field("word_byte", want.word_byte, got.word_byte);
            compare_field("byte_present", BYTE_W'(want.byte_present),
                          BYTE_W'(got.byte_present));
            compare_field("word_end", BYTE_W'(want.word_end), BYTE_W'(got.word_end));
            compare_field("string_end", BYTE_W'(want.string_end), BYTE_W'(got.string_end));
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Top of the tokenizer testbench. Strings are sent one byte per item on the text
// channel; every accepted item goes to the tracker, which predicts the word items
// it causes, and every accepted word item is checked against the oldest prediction.
// The separator registers are rewritten between phases, only once the block has
// gone quiet, so the predictor and the block always agree on the settings.
module tb_top;

    import msep_pkg::*;
    import word_check_pkg::*;

    localparam int CLK_PERIOD    = 10;
    // The block holds a chain of lookahead cells plus a four-entry output queue;
    // SETTLE_CYCLES is ample for it to empty after the last result.
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 34;
    localparam int RANDOM_PHASES = 6;
    localparam int LONG_HOLD     = 120;

    // Kinds of separator setting used by the directed and random phases.
    typedef enum int {
        SET_DIRECTED,
        SET_RANDOM,
        SET_ALL_ZERO,
        SET_ALL_ONES,
        SET_ZERO_BYTES
    } setting_kind_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   text_valid;
    logic                   text_stall;
    text_item_t             text_item;
    logic                   word_valid;
    logic                   word_stall;
    word_item_t             word_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    word_tracker tracker = new();

    // Bytes of the string that is sent next.
    logic [BYTE_W-1:0] string_bytes [$];

    // Values for the next configuration pass.
    logic [CFG_DATA_W-1:0] next_pattern [PATTERN_REGS];
    logic [CFG_DATA_W-1:0] next_lengths;

    // Idling control: a nonzero mode lets that side insert random idle bursts.
    int send_mode   = 0;
    int stall_mode  = 0;
    // A nonzero value asks the receiver for one long hold of that many cycles.
    int hold_cycles = 0;

    int bytes_sent    = 0;
    int strings_sent  = 0;
    int settings_used = 0;

    multi_separator_tokenizer #(
        .SEPARATOR_COUNT (TB_SEP_COUNT),
        .SEPARATOR_BYTES (TB_SEP_BYTES)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_item  (text_item),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_item  (word_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Both channels are sampled here in one process at the rising edge. All inputs
    // change through nonblocking assignments, so the values seen are the ones that
    // the block saw at this edge. Text is noted before words are checked, although
    // the block's latency keeps a word from depending on a text item of the same edge.
    always @(posedge clk)
    begin : observe
        if (rst_n)
        begin
            if (text_valid && !text_stall)
            begin
                tracker.split_text(text_item);
            end
            if (word_valid && !word_stall)
            begin
                tracker.check_word(word_item);
            end
        end
    end

    // The receiver. It stalls in random bursts while stall_mode is set, and serves
    // a long hold when the stimulus asks for one; the hold is counted here, so the
    // sender keeps offering items and the block has to fill up and stall its input.
    initial
    begin : receiver
        int k;
        word_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                k           = hold_cycles;
                hold_cycles = 0;
                word_stall <= 1'b1;
                repeat (k) @(posedge clk);
                word_stall <= 1'b0;
            end
            else if (stall_mode != 0 && $urandom_range(0, 4) == 0)
            begin
                word_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                word_stall <= 1'b0;
            end
        end
    end

    // Mostly letters a to c, which random separators are also built from, so that
    // matches, near misses and overlaps are common; now and then any byte at all.
    function automatic logic [BYTE_W-1:0] pattern_char();
        if ($urandom_range(0, 3) == 0)
        begin
            return BYTE_W'($urandom_range(0, 255));
        end
        return BYTE_W'("a" + $urandom_range(0, 2));
    endfunction

    // Builds a random string from whole separators of the current setting, broken
    // separators (a leading part only), word characters and plain noise. About one
    // string in six is made of separators only, to hit the marker-only result.
    function automatic void build_string(input int max_len);
        int pick;
        int sep;
        int n;
        bit sep_only;
        string_bytes.delete();
        sep_only = ($urandom_range(0, 5) == 0);
        while (string_bytes.size() < max_len)
        begin
            pick = sep_only ? 0 : $urandom_range(0, 9);
            if (pick <= 4)
            begin
                sep = $urandom_range(0, PATTERN_REGS - 1);
                n   = tracker.sep_len(sep);
                // An unused separator still lends its first byte as plain text.
                if (n == 0)
                begin
                    n = 1;
                end
                if (pick == 4 && n > 1)
                begin
                    n = $urandom_range(1, n - 1);
                end
                for (int k = 0; k < n; k++)
                begin
                    string_bytes.push_back(tracker.pattern[sep][BYTE_W*k +: BYTE_W]);
                end
            end
            else if (pick < 9)
            begin
                string_bytes.push_back(pattern_char());
            end
            else
            begin
                string_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end
        while (string_bytes.size() > max_len)
        begin
            void'(string_bytes.pop_back());
        end
    endfunction

    // Sends string_bytes, flagging the last item. Valid stays high from one item to
    // the next unless an idle burst comes between them; the caller lowers it once
    // the stimulus for a phase is done.
    task automatic send_string();
        text_item_t next_item;
        int         last_idx;
        last_idx = string_bytes.size() - 1;
        for (int i = 0; i <= last_idx; i++)
        begin
            next_item.text_byte  = string_bytes[i];
            next_item.final_byte = (i == last_idx);
            text_valid <= 1'b1;
            text_item  <= next_item;
            do @(posedge clk); while (text_stall);
            if (send_mode != 0 && $urandom_range(0, 3) == 0)
            begin
                text_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        bytes_sent   += string_bytes.size();
        strings_sent += 1;
    endtask

    // Stops the text side and waits for every predicted word item, then waits out the
    // settle time as well, so that nothing is still on its way.
    task automatic settle();
        int waited;
        waited = 0;
        text_valid <= 1'b0;
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; valid stays high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(idx, value);
    endtask

    // Picks a setting of the given kind and writes every register. The lengths
    // register always gets a full word so that its dropped upper bits are exercised,
    // and one index past the register map is written to show it is ignored.
    task automatic choose_settings(input setting_kind_t kind);
        logic [CFG_INDEX_W-1:0] spare_idx;
        for (int i = 0; i < PATTERN_REGS; i++)
        begin
            case (kind)
                SET_ALL_ZERO, SET_ZERO_BYTES: next_pattern[i] = '0;
                SET_ALL_ONES:                 next_pattern[i] = '1;
                SET_RANDOM:
                begin
                    for (int k = 0; k < PATTERN_BYTES; k++)
                    begin
                        next_pattern[i][BYTE_W*k +: BYTE_W] = pattern_char();
                    end
                end
                default: ;
            endcase
        end
        case (kind)
            SET_ALL_ZERO:   next_lengths = '0;
            SET_ALL_ONES:   next_lengths = '1;
            SET_ZERO_BYTES: next_lengths = {$urandom()} & ~32'(LENGTHS_RESET * 0 + {LENGTHS_W{1'b1}})
                                           | {4{3'd4}};
            SET_RANDOM:     next_lengths = $urandom();
            default: ;
        endcase
        for (int i = 0; i < PATTERN_REGS; i++)
        begin
            write_reg(REG_PATTERN_ZERO + CFG_INDEX_W'(i), next_pattern[i]);
        end
        write_reg(REG_PATTERN_LENGTHS, next_lengths);
        spare_idx = CFG_INDEX_W'($urandom_range(REG_PATTERN_LENGTHS + 1, (1 << CFG_INDEX_W) - 1));
        write_reg(spare_idx, $urandom());
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        int phase_end;
        rst_n      <= 1'b0;
        text_valid <= 1'b0;
        text_item  <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: a single space separator. Leading, doubled and trailing
        // spaces must give no empty words; a lone space gives a marker-only item;
        // byte values zero and all ones are ordinary text.
        settings_used = 1;
        send_mode     = 1;
        stall_mode    = 1;
        string_bytes = '{" ", "a", "b", " ", " ", "c", " "};
        send_string();
        string_bytes = '{8'hFF};
        send_string();
        string_bytes = '{" "};
        send_string();
        string_bytes = '{8'h00, "x"};
        send_string();
        settle();

        // Hand-picked setting: "ab", the four bytes "XYZW", a zero byte, and four
        // all-ones bytes whose length field is seven and saturates to four.
        next_pattern[0] = 32'h0000_6261;
        next_pattern[1] = 32'h575A_5958;
        next_pattern[2] = 32'h0000_0000;
        next_pattern[3] = 32'hFFFF_FFFF;
        next_lengths    = 32'hABCD_E000 | {3'd7, 3'd1, 3'd4, 3'd2};
        choose_settings(SET_DIRECTED);
        // Every separator in turn, ending on separators so the string closes with
        // a marker-only item.
        string_bytes = '{"a", "b", "q", 8'h00, "X", "Y", "Z", "W", "r",
                         8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_string();
        // The four byte separator cannot fit before the end, so this is one word.
        string_bytes = '{"X", "Y", "Z"};
        send_string();
        settle();

        // Random phases. Each has its own setting and idling mix; the fourth holds
        // the receiver off for a long stretch while text keeps coming, and the last
        // runs with no idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                1:       choose_settings(SET_ALL_ZERO);
                2:       choose_settings(SET_ALL_ONES);
                4:       choose_settings(SET_ZERO_BYTES);
                default: choose_settings(SET_RANDOM);
            endcase
            send_mode  = (phase == 0 || phase == 2 || phase == 4) ? 1 : 0;
            stall_mode = (phase == 2 || phase == 5) ? 0 : 1;
            if (phase == 3)
            begin
                hold_cycles = LONG_HOLD;
            end
            phase_end = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < phase_end)
            begin
                build_string(($urandom_range(0, 7) == 0) ? $urandom_range(11, 24)
                                                         : $urandom_range(1, 10));
                send_string();
            end
            settle();
        end

        if (tracker.pending() != 0)
        begin
            $display("%0t: %0d expected word items never arrived", $time, tracker.pending());
            tracker.failures++;
        end
        $display("Sent %0d strings (%0d text items) under %0d separator settings; %0d word items checked.",
                 strings_sent, bytes_sent, settings_used, tracker.words_checked);
        $display("Settings ranged from no separators to saturated all-ones, with a long output hold.");
        if (tracker.failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Backstop against a hung handshake; a correct run ends far sooner.
    initial
    begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
